// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the stub frame deinterleaver
// Request layouts for both channels, the decoded frame record and the
// slot and counter limits.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int NUM_LANES = 5;
	localparam int NUM_SLOTS = 5;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] FIRST_SLOT = 3'd0;
	localparam logic [2:0] LAST_SLOT = 3'd4;
	localparam logic [5:0] FRAME_NUMBER_MAX = 6'd63;
	localparam int START_BIT = 7;

	typedef struct packed {
		logic [7:0] lane0_byte;
		logic [7:0] lane1_byte;
		logic [7:0] lane2_byte;
		logic [7:0] lane3_byte;
		logic [7:0] lane4_byte;
		logic       window_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0] frame_number;
		logic [2:0] stub_slot;
		logic [2:0] stub_count;
		logic [7:0] stub_position;
		logic [3:0] stub_row;
		logic [2:0] stub_bend;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] position;
		logic [3:0] row;
		logic [2:0] bend;
	} stub_t;

	typedef struct packed {
		logic [5:0]                 number;
		logic [2:0]                 count;
		stub_t [NUM_SLOTS-1:0]      stubs;
	} frame_t;

endpackage
`default_nettype wire

// ===== rtl/sfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_front: cycle history, frame detection and bit deinterleave
// Keeps the previous bus cycle, rebuilds a frame record when the previous
// cycle carried a start mark, and numbers frames within the window.
// ----------------------------------------------------------------------------
module sfd_front
	import sfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output frame_t        frame,
	output logic          frame_valid
);

	logic [NUM_LANES-1:0][7:0] prev_q;
	logic                      prev_valid_q;
	logic [5:0]                frame_cnt_q;
	logic [NUM_LANES-1:0][7:0] p;
	logic [NUM_LANES-1:0][7:0] c;

	assign p = prev_q;
	assign c = {item.lane4_byte, item.lane3_byte, item.lane2_byte,
		item.lane1_byte, item.lane0_byte};

	// Detect a frame completed by this request
	assign frame_valid = accept && prev_valid_q && p[0][START_BIT];

	// Gather header and stubs from the previous and current cycles
	always_comb begin
		frame.number = frame_cnt_q;
		frame.count  = {p[1][7], p[2][7], p[3][7]};

		frame.stubs[0].position = {p[4][7], p[0][6], p[1][6], p[2][6],
			p[3][6], p[4][6], p[0][5], p[1][5]};
		frame.stubs[1].position = {p[4][4], p[0][3], p[1][3], p[2][3],
			p[3][3], p[4][3], p[0][2], p[1][2]};
		// Slot 2 merges two lanes into one bit and has a constant zero bit
		frame.stubs[2].position = {p[4][1], p[0][0], p[1][0], p[2][0],
			p[3][0] | p[4][0], 1'b0, c[1][7], c[2][7]};
		frame.stubs[3].position = {c[0][5], c[1][5], c[2][5], c[3][5],
			c[4][5], c[0][4], c[1][4], c[2][4]};
		frame.stubs[4].position = {c[0][2], c[1][2], c[2][2], c[3][2],
			c[4][2], c[0][1], c[1][1], c[2][1]};

		frame.stubs[0].row = {p[0][4], p[1][4], p[2][4], p[3][4]};
		frame.stubs[1].row = {p[0][1], p[1][1], p[2][1], p[3][1]};
		frame.stubs[2].row = {c[1][6], c[2][6], c[3][6], c[4][6]};
		frame.stubs[3].row = {c[1][3], c[2][3], c[3][3], c[4][3]};
		frame.stubs[4].row = {c[1][0], c[2][0], c[3][0], c[4][0]};

		frame.stubs[0].bend = {p[2][5], p[3][5], p[4][5]};
		frame.stubs[1].bend = {p[2][2], p[3][2], p[4][2]};
		frame.stubs[2].bend = {c[3][7], c[4][7], c[0][6]};
		frame.stubs[3].bend = {c[3][4], c[4][4], c[0][3]};
		frame.stubs[4].bend = {c[3][1], c[4][1], c[0][0]};
	end

	// Advance history and frame number; clear all at window end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			frame_cnt_q  <= '0;
		end else if (accept) begin
			if (item.window_end) begin
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				frame_cnt_q  <= '0;
			end else begin
				prev_q       <= c;
				prev_valid_q <= 1'b1;
				if (frame_valid && frame_cnt_q != FRAME_NUMBER_MAX) begin
					frame_cnt_q <= frame_cnt_q + 6'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sfd_frame_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_frame_queue: short frame record queue
// Decouples the front part from the slot sequencer.
// ----------------------------------------------------------------------------
module sfd_frame_queue
	import sfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire frame_t wdata,
	output logic        full,
	input  wire logic   pop,
	output frame_t      rdata,
	output logic        empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store pushed records
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_back: slot sequencer
// Holds one frame record and hands out its five stub slots in order,
// reloading from the queue as the last slot is taken.
// ----------------------------------------------------------------------------
module sfd_back
	import sfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire frame_t q_data,
	input  wire logic   q_empty,
	output logic        q_pop,
	output out_item_t   result,
	output logic        empty,
	input  wire logic   pop
);

	frame_t     frame_q;
	logic [2:0] slot_q;
	logic       busy_q;
	logic       taken;
	logic       last_taken;

	assign empty      = !busy_q;
	assign taken      = pop && busy_q;
	assign last_taken = taken && (slot_q == LAST_SLOT);
	assign q_pop      = (!busy_q || last_taken) && !q_empty;

	// Present the current slot
	always_comb begin
		result.frame_number  = frame_q.number;
		result.stub_slot     = slot_q;
		result.stub_count    = frame_q.count;
		result.stub_position = frame_q.stubs[slot_q].position;
		result.stub_row      = frame_q.stubs[slot_q].row;
		result.stub_bend     = frame_q.stubs[slot_q].bend;
		result.frame_last    = (slot_q == LAST_SLOT);
	end

	// Load the next frame record
	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_data;
		end
	end

	// Advance the slot; drop to idle when no record waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= FIRST_SLOT;
			busy_q <= 1'b0;
		end else if (q_pop) begin
			slot_q <= FIRST_SLOT;
			busy_q <= 1'b1;
		end else if (last_taken) begin
			busy_q <= 1'b0;
		end else if (taken) begin
			slot_q <= slot_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/stub_frame_deinterleaver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stub_frame_deinterleaver: five-line stub link frame rebuilder
// Rebuilds stub frames from the previous and current bus cycles and emits their five stub slots.
// ----------------------------------------------------------------------------
//  channel | handshake    | payload            | meaning
//  input   | push / full  | item   (in_item_t) | one bus cycle, five bytes
//  result  | pop  / empty | result (out_item_t)| one stub slot of a frame
//
// One bus cycle is taken per clock while the frame queue has room.
// A completed frame gives five results, one per clock while pop is held,
// from the sequencer output register; the sequencer loads the next frame
// record only when it is idle or its last slot is taken. A frame record
// lands in the queue at its accepting edge. Reset clears the history, the
// frame number, queue and sequencer; full rises only when the queue fills.
// ----------------------------------------------------------------------------
module stub_frame_deinterleaver
	import sfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	input  wire logic     pop,
	output out_item_t     result,
	output logic          empty
);

	logic   accept;
	frame_t frame;
	logic   frame_valid;
	frame_t q_data;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	sfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.frame       (frame),
		.frame_valid (frame_valid)
	);

	sfd_frame_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (frame_valid),
		.wdata  (frame),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	sfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
`default_nettype wire

// ===== tb/sv/sfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: scoreboard for the stub frame deinterleaver
// Watches both queue channels, rebuilds each frame from the accepted bus
// cycles and compares every popped stub slot field by field in order.
// ----------------------------------------------------------------------------
module sfd_checker
	import sfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire logic     full,
	input  wire in_item_t item,
	input  wire logic     pop,
	input  wire logic     empty,
	input  wire out_item_t result,
	output int            errors,
	output int            outstanding,
	output int            slots_checked
);

	localparam int REPORT_LIMIT = 10;

	// shadow of the block's history and frame numbering
	logic [NUM_LANES-1:0][7:0] held_lanes;
	logic                      held_valid;
	logic [5:0]                frame_idx;

	// stub slots predicted but not yet popped, oldest first
	out_item_t slots_due[$];

	// Rebuild the frame that this bus cycle completes, if any, and advance history.
	task automatic take_bus_cycle(input in_item_t it);
		logic [NUM_LANES-1:0][7:0] c;
		logic [NUM_LANES-1:0][7:0] p;
		logic [2:0]                cnt;
		logic [7:0]                pos [NUM_SLOTS];
		logic [3:0]                row [NUM_SLOTS];
		logic [2:0]                bend [NUM_SLOTS];
		out_item_t                 slot;
		int                        k;
		c[0] = it.lane0_byte;
		c[1] = it.lane1_byte;
		c[2] = it.lane2_byte;
		c[3] = it.lane3_byte;
		c[4] = it.lane4_byte;
		p = held_lanes;
		if (held_valid && p[0][START_BIT]) begin
			cnt = {p[1][7], p[2][7], p[3][7]};

			pos[0] = {p[4][7], p[0][6], p[1][6], p[2][6], p[3][6], p[4][6], p[0][5], p[1][5]};
			pos[1] = {p[4][4], p[0][3], p[1][3], p[2][3], p[3][3], p[4][3], p[0][2], p[1][2]};
			// lines 3 and 4 share bit 3 here; bit 2 carries nothing
			pos[2] = {p[4][1], p[0][0], p[1][0], p[2][0], p[3][0] | p[4][0], 1'b0,
				c[1][7], c[2][7]};
			pos[3] = {c[0][5], c[1][5], c[2][5], c[3][5], c[4][5], c[0][4], c[1][4], c[2][4]};
			pos[4] = {c[0][2], c[1][2], c[2][2], c[3][2], c[4][2], c[0][1], c[1][1], c[2][1]};

			row[0] = {p[0][4], p[1][4], p[2][4], p[3][4]};
			row[1] = {p[0][1], p[1][1], p[2][1], p[3][1]};
			row[2] = {c[1][6], c[2][6], c[3][6], c[4][6]};
			row[3] = {c[1][3], c[2][3], c[3][3], c[4][3]};
			row[4] = {c[1][0], c[2][0], c[3][0], c[4][0]};

			bend[0] = {p[2][5], p[3][5], p[4][5]};
			bend[1] = {p[2][2], p[3][2], p[4][2]};
			bend[2] = {c[3][7], c[4][7], c[0][6]};
			bend[3] = {c[3][4], c[4][4], c[0][3]};
			bend[4] = {c[3][1], c[4][1], c[0][0]};

			for (k = 0; k < NUM_SLOTS; k++) begin
				slot.frame_number = frame_idx;
				slot.stub_slot = 3'(k);
				slot.stub_count = cnt;
				slot.stub_position = pos[k];
				slot.stub_row = row[k];
				slot.stub_bend = bend[k];
				slot.frame_last = (slot.stub_slot == LAST_SLOT);
				slots_due.insert(slots_due.size(), slot);
			end
			// saturate the frame number
			if (frame_idx != FRAME_NUMBER_MAX)
				frame_idx++;
		end
		if (it.window_end) begin
			held_lanes = '0;
			held_valid = 1'b0;
			frame_idx = '0;
		end else begin
			held_lanes = c;
			held_valid = 1'b1;
		end
	endtask

	// Check popped slots first, then predict from the accepted bus cycle.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			held_lanes = '0;
			held_valid = 1'b0;
			frame_idx = '0;
			errors = 0;
			slots_checked = 0;
			slots_due.delete();
		end else begin
			if (pop && !empty) begin
				if (slots_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%t: unexpected stub slot popped: frame %0d slot %0d",
							$realtime, result.frame_number, result.stub_slot);
				end else begin
					want = slots_due.pop_front();
					slots_checked++;
					if (result.frame_number !== want.frame_number ||
							result.stub_slot !== want.stub_slot ||
							result.stub_count !== want.stub_count ||
							result.stub_position !== want.stub_position ||
							result.stub_row !== want.stub_row ||
							result.stub_bend !== want.stub_bend ||
							result.frame_last !== want.frame_last) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("%t: want frm %0d slot %0d cnt %0d pos %h row %h bnd %0d",
								$realtime, want.frame_number, want.stub_slot,
								want.stub_count, want.stub_position, want.stub_row,
								want.stub_bend);
							$display("%t:   want last %0d", $realtime, want.frame_last);
							$display("%t: got  frm %0d slot %0d cnt %0d pos %h row %h bnd %0d",
								$realtime, result.frame_number, result.stub_slot,
								result.stub_count, result.stub_position, result.stub_row,
								result.stub_bend);
							$display("%t:   got  last %0d", $realtime, result.frame_last);
						end
					end
				end
			end
			if (push && !full)
				take_bus_cycle(item);
		end
		outstanding = slots_due.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the stub frame deinterleaver
// Drives bus cycles into the block under changing idle patterns, holds off
// the result side to fill the frame queue, walks one window past frame
// number saturation and lets the checker score every stub slot.
// ----------------------------------------------------------------------------
module tb;
	import sfd_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int QUIET_LIMIT = 5000;
	localparam int SATURATION_FRAMES = 70;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	in_item_t  item = '0;
	logic      full;
	logic      pop = 1'b0;
	out_item_t result;
	logic      empty;

	int errors;
	int outstanding;
	int slots_checked;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off_req = 1'b0;
	int cycles_sent = 0;
	int windows_closed = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	stub_frame_deinterleaver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (pop),
		.result (result),
		.empty  (empty)
	);

	sfd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.pop           (pop),
		.empty         (empty),
		.result        (result),
		.errors        (errors),
		.outstanding   (outstanding),
		.slots_checked (slots_checked)
	);

	function automatic in_item_t bus_cycle(input logic [7:0] l0, input logic [7:0] l1,
			input logic [7:0] l2, input logic [7:0] l3, input logic [7:0] l4, input logic we);
		bus_cycle = {l0, l1, l2, l3, l4, we};
	endfunction

	// Mostly frame-friendly cycles with rare window ends, some pure noise.
	function automatic in_item_t random_cycle();
		in_item_t it;
		it = bus_cycle(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 1'($urandom_range(1)));
		if ($urandom_range(99) < 85) begin
			it.lane0_byte[START_BIT] = ($urandom_range(9) < 6);
			it.window_end = ($urandom_range(24) == 0);
		end
		return it;
	endfunction

	// Offer one bus cycle; hold it until the block takes the request.
	task automatic offer(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		cycles_sent++;
		if (it.window_end)
			windows_closed++;
	endtask

	task automatic offer_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			offer(random_cycle());
	endtask

	// Drop push and wait for every predicted slot to drain.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// Result side: random pops, with one long hold-off on request.
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES)
					@(posedge clk);
				held = 1'b1;
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when no request moves for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int i;
		in_item_t it;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow sender, mostly stalled receiver
		send_idle_pct = 35;
		recv_idle_pct = 86;

		// header on the first cycle of a window gives nothing
		offer(bus_cycle(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		// back-to-back headers: all ones frame, then ones into zeros
		offer(bus_cycle(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		offer(bus_cycle(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(bus_cycle(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(bus_cycle(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(bus_cycle(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
		offer(bus_cycle(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
		// full stub count, line 3 bit 0 alone feeding the shared position bit
		offer(bus_cycle(8'h81, 8'h80, 8'h80, 8'h81, 8'h00, 1'b0));
		offer(bus_cycle(8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'h0F, 1'b0));
		// line 4 bit 0 alone on the shared position bit
		offer(bus_cycle(8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0));
		offer(bus_cycle(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0));
		// header on the closing cycle is forgotten
		offer(bus_cycle(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		offer(bus_cycle(8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 1'b0));
		// closing cycle still completes its frame
		offer(bus_cycle(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b1));
		offer(bus_cycle(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0));
		offer(bus_cycle(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
		offer(bus_cycle(8'h80, 8'h00, 8'h80, 8'h00, 8'hFF, 1'b0));
		offer(bus_cycle(8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 1'b0));
		offer(bus_cycle(8'hC0, 8'h20, 8'h40, 8'h80, 8'h7F, 1'b0));
		offer(bus_cycle(8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 1'b1));

		offer_random(60);

		// stall the result side and keep frames coming until full
		hold_off_req = 1'b1;
		for (i = 0; i < 30; i++) begin
			it = random_cycle();
			it.lane0_byte[START_BIT] = 1'b1;
			it.window_end = 1'b0;
			offer(it);
		end

		// mostly idle sender, busy receiver
		send_idle_pct = 86;
		recv_idle_pct = 35;
		offer_random(90);
		drain_results();

		// no idling: one long window past frame number saturation
		send_idle_pct = 0;
		recv_idle_pct = 0;
		offer(bus_cycle(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		for (i = 0; i <= SATURATION_FRAMES; i++) begin
			it = random_cycle();
			it.lane0_byte[START_BIT] = 1'b1;
			it.window_end = (i == SATURATION_FRAMES);
			offer(it);
		end
		offer_random(40);

		drain_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Run covered %0d bus cycles in %0d closed windows, %0d stub slots checked.",
			cycles_sent, windows_closed, slots_checked);
		$display("Included queue fill under receiver hold-off and frame number saturation.");
		if (outstanding != 0)
			$display("%0d predicted stub slots never popped", outstanding);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
